[hw/rtl/sorted_frequency_table_core_defines.svh]
// Assertion macros of the sorted frequency table RTL.
`ifndef SORTED_FREQUENCY_TABLE_CORE_DEFINES_SVH
`define SORTED_FREQUENCY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SFT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/sft_pkg.sv]
// Types, constants and codes of the sorted frequency table.
package sft_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int CNT_W       = 32;
	localparam int POS_W       = 7;
	localparam int USED_W      = 8;

	localparam logic REQ_COUNT = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] ST_HIT    = 2'd0;
	localparam logic [1:0] ST_INSERT = 2'd1;
	localparam logic [1:0] ST_MISS   = 2'd2;
	localparam logic [1:0] ST_DROP   = 2'd3;

	typedef struct packed {
		logic                    req_type;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CNT_W-1:0]  occurrences;
		logic [POS_W-1:0]  position;
		logic [USED_W-1:0] entries_used;
	} rsp_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		logic                    cmp_en;
		logic signed [KEY_W-1:0] cmp_key;
		logic                    upd_en;
		logic signed [KEY_W-1:0] key;
		logic                    query;
		logic                    insert;
	} cell_cmd_t;

	// What a cell hands to its upper neighbor.
	typedef struct packed {
		logic                    valid;
		logic                    ge;
		logic signed [KEY_W-1:0] key;
		logic [CNT_W-1:0]        count;
	} cell_link_t;

	// Per-cell status back to the controller.
	typedef struct packed {
		logic             eq;
		logic             sel;
		logic [CNT_W-1:0] occ;
	} cell_stat_t;

endpackage

[hw/rtl/sft_cell.sv]
// One table cell: a key, its count, a valid bit and the compare flags.
module sft_cell import sft_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cell_cmd_t  cmd,
	input  cell_link_t left,
	output cell_link_t right,
	output cell_stat_t stat
);

	logic                    valid_q;
	logic                    ge_q;
	logic                    eq_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        sat_count;
	logic                    slot_here;

	assign sat_count = (count_q == '1) ? count_q : count_q + CNT_W'(1);

	// First entry not below the key, or the first free entry.
	assign slot_here = !left.ge && left.valid && (ge_q || !valid_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ge_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (cmd.cmp_en) begin
				ge_q <= valid_q && (key_q >= cmd.cmp_key);
				eq_q <= valid_q && (key_q == cmd.cmp_key);
			end
			if (cmd.upd_en && cmd.insert && (left.ge || slot_here)) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_en) begin
			if (cmd.insert) begin
				if (left.ge) begin
					key_q   <= left.key;
					count_q <= left.count;
				end else if (slot_here) begin
					key_q   <= cmd.key;
					count_q <= CNT_W'(1);
				end
			end else if (eq_q && !cmd.query) begin
				count_q <= sat_count;
			end
		end
	end

	assign right = '{valid: valid_q, ge: ge_q, key: key_q, count: count_q};

	assign stat.eq  = eq_q;
	assign stat.sel = slot_here;
	assign stat.occ = eq_q ? (cmd.query ? count_q : sat_count) : '0;

endmodule

[hw/rtl/sorted_frequency_table_core.sv]
// Top level of the sorted frequency table: controller and row of cells.
//
// A sorted table of up to TABLE_DEPTH distinct signed keys, each with a
// saturating occurrence count, held in a row of cells (one entry per cell,
// smallest key in cell 0). A request is taken at a clock edge where start
// is high and busy is low. A count request bumps the count of a present key
// or inserts an absent key in order with count 1, the larger entries each
// moving up one cell; a query request only reads. At the accepting edge each
// cell compares its key against the request key, and at the next edge the
// cells increment or shift in place while the result is registered. busy is
// high between those edges, so no new request is taken while one is in
// progress. The result shows on rsp for exactly one cycle with done high and
// cannot be held off; capture it then. The table is empty right after reset
// (valid bits clear), with no clearing pass. An insert into a full table is
// dropped and flagged.
`include "sorted_frequency_table_core_defines.svh"

module sorted_frequency_table_core import sft_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic {
		IDLE,
		UPDATE
	} state_t;

	state_t              state_q;
	logic [FILL_W-1:0]   fill_q;
	logic                done_q;
	rsp_t                rsp_q;
	req_t                req_q;

	cell_cmd_t           cmd;
	cell_link_t          head;
	cell_link_t          link   [TABLE_DEPTH];
	cell_stat_t          stat   [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] eq_vec;
	logic [TABLE_DEPTH-1:0] sel_vec;

	logic                hit;
	logic                full;
	logic [CNT_W-1:0]    hit_occ;
	logic [IDX_W-1:0]    slot_idx;
	rsp_t                rsp_next;
	logic [FILL_W-1:0]   fill_next;

	logic accept;

	assign accept = start && (state_q == IDLE);
	assign busy   = (state_q != IDLE);
	assign full   = (fill_q == FILL_W'(TABLE_DEPTH));

	// Hold the request for the update cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	// Compare straight off the ports at accept; update in the following cycle.
	always_comb begin
		cmd.cmp_en  = accept;
		cmd.cmp_key = req.key;
		cmd.upd_en  = (state_q == UPDATE);
		cmd.key     = req_q.key;
		cmd.query   = (req_q.req_type == REQ_QUERY);
		cmd.insert  = !hit && (req_q.req_type == REQ_COUNT) && !full;
	end

	// Cell 0 sees a virtual lower neighbor that is valid and below every key.
	assign head = '{valid: 1'b1, ge: 1'b0, key: '0, count: '0};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			sft_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.left  (head),
				.right (link[i]),
				.stat  (stat[i])
			);
		end else begin : g_rest
			sft_cell u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.cmd   (cmd),
				.left  (link[i-1]),
				.right (link[i]),
				.stat  (stat[i])
			);
		end
		assign eq_vec[i]  = stat[i].eq;
		assign sel_vec[i] = stat[i].sel;
	end

	assign hit = |eq_vec;

	// Gather the count of the hit cell and encode the one-hot slot.
	always_comb begin
		hit_occ  = '0;
		slot_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_occ  = hit_occ | stat[i].occ;
			slot_idx = slot_idx | (sel_vec[i] ? IDX_W'(i) : IDX_W'(0));
		end
	end

	// Build the response of the request in its update cycle.
	always_comb begin
		fill_next = fill_q;
		if (hit) begin
			rsp_next.status      = ST_HIT;
			rsp_next.occurrences = hit_occ;
			rsp_next.position    = POS_W'(slot_idx);
		end else if (req_q.req_type == REQ_QUERY) begin
			rsp_next.status      = ST_MISS;
			rsp_next.occurrences = '0;
			rsp_next.position    = '0;
		end else if (full) begin
			rsp_next.status      = ST_DROP;
			rsp_next.occurrences = '0;
			rsp_next.position    = '0;
		end else begin
			rsp_next.status      = ST_INSERT;
			rsp_next.occurrences = CNT_W'(1);
			rsp_next.position    = POS_W'(slot_idx);
			fill_next            = fill_q + FILL_W'(1);
		end
		rsp_next.entries_used = USED_W'(fill_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						state_q <= UPDATE;
					end
				end
				UPDATE: begin
					fill_q  <= fill_next;
					rsp_q   <= rsp_next;
					done_q  <= 1'b1;
					state_q <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Keys stay distinct, so at most one cell can match.
	`SFT_ASSERT_NOW(a_single_match, state_q == UPDATE, $onehot0(eq_vec), "several cells match")
	// The slot marker is unique because valid entries are contiguous and sorted.
	`SFT_ASSERT_NOW(a_single_slot, state_q == UPDATE, $onehot0(sel_vec), "several slots marked")
	// Every accepted request passes through UPDATE and yields the done strobe.
	`SFT_ASSERT_NEXT(a_result_follows, state_q == UPDATE, done, "result strobe missing")
	// An insert grows the table by exactly one entry.
	`SFT_ASSERT_NOW(a_insert_grows, done && (rsp_q.status == ST_INSERT), fill_q == $past(fill_q) + FILL_W'(1), "fill level off after insert")

endmodule
